// ===== rtl/cau_pkg.sv =====
// package for the complex arithmetic unit: operation and status codes, default sizes
// no dependencies; used by complex_arithmetic_unit_core and cau_checker
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;

    // operation codes carried in kind
    typedef enum logic [2:0] {
        K_ADD   = 3'd0,
        K_SUB   = 3'd1,
        K_MUL   = 3'd2,
        K_DIV   = 3'd3,
        K_CONJ  = 3'd4,
        K_ABS   = 3'd5,
        K_SQABS = 3'd6
    } kind_t;

    // result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

endpackage

// ===== rtl/complex_arithmetic_unit_core.sv =====
// complex arithmetic unit: add, sub, mul, div, conj, abs, squared abs in signed fixed point
// depends on cau_pkg
// an accepted item passes the product, sum, divider and root stages and the result register
// throughput one item per cycle unless a held result stalls; the divider and square root give one quotient or
// root bit per stage, so the pipeline depth follows DATA_WIDTH
// a held result stalls the whole pipeline; rst_n clears all valid bits asynchronously
module complex_arithmetic_unit_core #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         op_valid,
    output logic                         op_stall,
    input  logic [2:0]                   kind,
    input  logic signed [DATA_WIDTH-1:0] a_real,
    input  logic signed [DATA_WIDTH-1:0] a_imag,
    input  logic signed [DATA_WIDTH-1:0] b_real,
    input  logic signed [DATA_WIDTH-1:0] b_imag,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic signed [DATA_WIDTH-1:0] res_real,
    output logic signed [DATA_WIDTH-1:0] res_imag,
    output logic [1:0]                   status
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int NW = 3 * W + F;
    localparam int RW = 2 * W + 2;

    localparam logic signed [SW-1:0] POS_S = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] NEG_S = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [W-1:0]  MAX_V = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  MIN_V = {1'b1, {(W-1){1'b0}}};
    localparam logic [W:0]           NEG_LIM = {2'b01, {(W-1){1'b0}}};

    typedef struct packed {
        logic signed [W-1:0] v;
        logic                f;
    } sat_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic signed [W-1:0]  ar;
        logic signed [W-1:0]  ai;
        logic signed [W-1:0]  br;
        logic signed [W-1:0]  bi;
        logic signed [PW-1:0] p_rr;
        logic signed [PW-1:0] p_ii;
        logic signed [PW-1:0] p_ri;
        logic signed [PW-1:0] p_ir;
        logic signed [PW-1:0] p_bbr;
        logic signed [PW-1:0] p_bbi;
        logic signed [PW-1:0] p_aar;
        logic signed [PW-1:0] p_aai;
    } s1_t;

    typedef struct packed {
        logic [2:0]           kind;
        logic signed [W-1:0]  rr;
        logic signed [W-1:0]  ri;
        logic                 flag;
        logic signed [SW-1:0] num_re;
        logic signed [SW-1:0] num_im;
        logic [PW-1:0]        den;
        logic [PW-1:0]        sq;
    } s2_t;

    typedef struct packed {
        logic [2:0]          kind;
        logic signed [W-1:0] rr;
        logic signed [W-1:0] ri;
        logic                flag;
        logic                neg_re;
        logic                neg_im;
        logic                zero;
        logic                ov_re;
        logic                ov_im;
        logic [NW-1:0]       r_re;
        logic [NW-1:0]       r_im;
        logic [W-1:0]        q_re;
        logic [W-1:0]        q_im;
        logic [PW-1:0]       den;
        logic [RW-1:0]       rem;
        logic [W-1:0]        root;
    } dv_t;

    // saturate a wide signed value to the component range
    function automatic sat_t sat_sum(input logic signed [SW-1:0] v);
        sat_t s;
        s.f = 1'b0;
        if (v > POS_S)
        begin
            s.v = MAX_V;
            s.f = 1'b1;
        end
        else if (v < NEG_S)
        begin
            s.v = MIN_V;
            s.f = 1'b1;
        end
        else
        begin
            s.v = v[W-1:0];
        end
        return s;
    endfunction

    // floor a quotient magnitude with its sign, then saturate
    function automatic sat_t div_fin(input logic neg, input logic ov,
                                     input logic [W-1:0] q, input logic rnz);
        sat_t       s;
        logic [W:0] mq;
        logic [W:0] mq_neg;
        mq     = {1'b0, q} + {{W{1'b0}}, rnz};
        mq_neg = -mq;
        s.f    = 1'b0;
        if (neg)
        begin
            if (ov || (mq > NEG_LIM))
            begin
                s.v = MIN_V;
                s.f = 1'b1;
            end
            else
            begin
                s.v = mq_neg[W-1:0];
            end
        end
        else
        begin
            if (ov || q[W-1])
            begin
                s.v = MAX_V;
                s.f = 1'b1;
            end
            else
            begin
                s.v = q;
            end
        end
        return s;
    endfunction

    logic          adv;
    logic [W+2:0]  vld_reg;
    logic          res_valid_reg;
    s1_t           s1_reg, s1_next;
    s2_t           s2_reg, s2_next;
    dv_t           s3_next;
    dv_t           pipe_reg [0:W];
    dv_t           pipe_next [0:W];
    logic signed [W-1:0] res_real_reg, res_real_next;
    logic signed [W-1:0] res_imag_reg, res_imag_next;
    logic [1:0]          status_reg, status_next;

    // pipeline moves unless a held result waits
    assign adv      = !(res_valid_reg && res_stall);
    assign op_stall = !adv;

    // stage 1: all products
    always_comb
    begin
        s1_next.kind  = kind;
        s1_next.ar    = a_real;
        s1_next.ai    = a_imag;
        s1_next.br    = b_real;
        s1_next.bi    = b_imag;
        s1_next.p_rr  = a_real * b_real;
        s1_next.p_ii  = a_imag * b_imag;
        s1_next.p_ri  = a_real * b_imag;
        s1_next.p_ir  = a_imag * b_real;
        s1_next.p_bbr = b_real * b_real;
        s1_next.p_bbi = b_imag * b_imag;
        s1_next.p_aar = a_real * a_real;
        s1_next.p_aai = a_imag * a_imag;
    end

    // stage 2: sums, and the results of the simple operations
    always_comb
    begin
        logic signed [SW-1:0] mul_re;
        logic signed [SW-1:0] mul_im;
        sat_t                 sr;
        sat_t                 si;
        mul_re = SW'(s1_reg.p_rr) - SW'(s1_reg.p_ii);
        mul_im = SW'(s1_reg.p_ri) + SW'(s1_reg.p_ir);
        s2_next.kind   = s1_reg.kind;
        s2_next.num_re = SW'(s1_reg.p_rr) + SW'(s1_reg.p_ii);
        s2_next.num_im = SW'(s1_reg.p_ir) - SW'(s1_reg.p_ri);
        s2_next.den    = $unsigned(s1_reg.p_bbr) + $unsigned(s1_reg.p_bbi);
        s2_next.sq     = $unsigned(s1_reg.p_aar) + $unsigned(s1_reg.p_aai);
        sr = '0;
        si = '0;
        case (s1_reg.kind)
            cau_pkg::K_ADD:
            begin
                sr = sat_sum(SW'(s1_reg.ar) + SW'(s1_reg.br));
                si = sat_sum(SW'(s1_reg.ai) + SW'(s1_reg.bi));
            end
            cau_pkg::K_SUB:
            begin
                sr = sat_sum(SW'(s1_reg.ar) - SW'(s1_reg.br));
                si = sat_sum(SW'(s1_reg.ai) - SW'(s1_reg.bi));
            end
            cau_pkg::K_MUL:
            begin
                sr = sat_sum(mul_re >>> F);
                si = sat_sum(mul_im >>> F);
            end
            cau_pkg::K_CONJ:
            begin
                sr.v = s1_reg.ar;
                sr.f = 1'b0;
                si   = sat_sum(-SW'(s1_reg.ai));
            end
            cau_pkg::K_SQABS:
            begin
                sr = sat_sum(SW'({1'b0, s2_next.sq >> F}));
            end
            default:
            begin
                sr = '0;
                si = '0;
            end
        endcase
        s2_next.rr   = sr.v;
        s2_next.ri   = si.v;
        s2_next.flag = sr.f | si.f;
    end

    // stage 3: sign and magnitude of the division numerators
    always_comb
    begin
        logic [SW-1:0] abs_re;
        logic [SW-1:0] abs_im;
        abs_re = s2_reg.num_re[SW-1] ? -s2_reg.num_re : s2_reg.num_re;
        abs_im = s2_reg.num_im[SW-1] ? -s2_reg.num_im : s2_reg.num_im;
        s3_next.kind   = s2_reg.kind;
        s3_next.rr     = s2_reg.rr;
        s3_next.ri     = s2_reg.ri;
        s3_next.flag   = s2_reg.flag;
        s3_next.neg_re = s2_reg.num_re[SW-1];
        s3_next.neg_im = s2_reg.num_im[SW-1];
        s3_next.zero   = (s2_reg.den == '0);
        s3_next.ov_re  = 1'b0;
        s3_next.ov_im  = 1'b0;
        s3_next.r_re   = NW'(abs_re[PW-1:0]);
        s3_next.r_im   = NW'(abs_im[PW-1:0]);
        s3_next.q_re   = '0;
        s3_next.q_im   = '0;
        s3_next.den    = s2_reg.den;
        s3_next.rem    = RW'(s2_reg.sq);
        s3_next.root   = '0;
    end

    // stage 3 also scales numerators and checks quotient overflow; then one bit per stage
    always_comb
    begin
        logic [NW-1:0] dre;
        logic [RW-1:0] trial;
        for (int j = 0; j <= W; j++)
        begin
            pipe_next[j] = pipe_reg[j];
        end
        pipe_next[0]       = s3_next;
        pipe_next[0].r_re  = s3_next.r_re << F;
        pipe_next[0].r_im  = s3_next.r_im << F;
        pipe_next[0].ov_re = (s3_next.r_re << F) >= (NW'(s3_next.den) << W);
        pipe_next[0].ov_im = (s3_next.r_im << F) >= (NW'(s3_next.den) << W);
        for (int j = 0; j < W; j++)
        begin
            pipe_next[j+1] = pipe_reg[j];
            // quotient bit W-1-j of both components
            dre = NW'(pipe_reg[j].den) << (W - 1 - j);
            if (pipe_reg[j].r_re >= dre)
            begin
                pipe_next[j+1].r_re = pipe_reg[j].r_re - dre;
                pipe_next[j+1].q_re[W-1-j] = 1'b1;
            end
            if (pipe_reg[j].r_im >= dre)
            begin
                pipe_next[j+1].r_im = pipe_reg[j].r_im - dre;
                pipe_next[j+1].q_im[W-1-j] = 1'b1;
            end
            // root bit W-1-j
            trial = (RW'(pipe_reg[j].root) << (W - j)) | (RW'(1) << (2 * (W - 1 - j)));
            if (pipe_reg[j].rem >= trial)
            begin
                pipe_next[j+1].rem = pipe_reg[j].rem - trial;
                pipe_next[j+1].root[W-1-j] = 1'b1;
            end
        end
    end

    // final stage: pick and saturate the result
    always_comb
    begin
        sat_t sr;
        sat_t si;
        sr = '0;
        si = '0;
        status_next = cau_pkg::ST_OK;
        case (pipe_reg[W].kind)
            cau_pkg::K_DIV:
            begin
                if (!pipe_reg[W].zero)
                begin
                    sr = div_fin(pipe_reg[W].neg_re, pipe_reg[W].ov_re, pipe_reg[W].q_re,
                                 pipe_reg[W].r_re != '0);
                    si = div_fin(pipe_reg[W].neg_im, pipe_reg[W].ov_im, pipe_reg[W].q_im,
                                 pipe_reg[W].r_im != '0);
                end
            end
            cau_pkg::K_ABS:
            begin
                if (pipe_reg[W].root[W-1])
                begin
                    sr.v = MAX_V;
                    sr.f = 1'b1;
                end
                else
                begin
                    sr.v = pipe_reg[W].root;
                end
            end
            default:
            begin
                sr.v = pipe_reg[W].rr;
                sr.f = pipe_reg[W].flag;
                si.v = pipe_reg[W].ri;
            end
        endcase
        res_real_next = sr.v;
        res_imag_next = si.v;
        if ((pipe_reg[W].kind == cau_pkg::K_DIV) && pipe_reg[W].zero)
        begin
            status_next = cau_pkg::ST_DZ;
        end
        else if (sr.f || si.f)
        begin
            status_next = cau_pkg::ST_SAT;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[W+1:0], op_valid};
            res_valid_reg <= vld_reg[W+2];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            for (int j = 0; j <= W; j++)
            begin
                pipe_reg[j] <= pipe_next[j];
            end
            res_real_reg <= res_real_next;
            res_imag_reg <= res_imag_next;
            status_reg   <= status_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_real  = res_real_reg;
    assign res_imag  = res_imag_reg;
    assign status    = status_reg;

endmodule

// ===== rtl/cau_checker.sv =====
// port checks for the complex arithmetic unit, bound to the top level
// depends on cau_pkg and complex_arithmetic_unit_core
module cau_checker #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         op_valid,
    input logic                         op_stall,
    input logic [2:0]                   kind,
    input logic signed [DATA_WIDTH-1:0] a_real,
    input logic signed [DATA_WIDTH-1:0] a_imag,
    input logic signed [DATA_WIDTH-1:0] b_real,
    input logic signed [DATA_WIDTH-1:0] b_imag,
    input logic                         res_valid,
    input logic                         res_stall,
    input logic signed [DATA_WIDTH-1:0] res_real,
    input logic signed [DATA_WIDTH-1:0] res_imag,
    input logic [1:0]                   status
);

    // a held result back-pressures the input
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |-> op_stall)
        else $error("input taken while result held");

    // status code in range
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((status == cau_pkg::ST_OK) || (status == cau_pkg::ST_SAT)
                       || (status == cau_pkg::ST_DZ)))
        else $error("undefined status");

    // zero divisor gives zero result
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (status == cau_pkg::ST_DZ)) |-> (res_real == '0 && res_imag == '0))
        else $error("division by zero result not zero");

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(res_real) && $stable(res_imag)
                                      && $stable(status)))
        else $error("stalled result changed");

endmodule

bind complex_arithmetic_unit_core cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (.*);
